/* sv/ofau_pkg.sv */
`timescale 1ns / 1ps
// Package for the oscillating force acceleration update: sizes, codes and the sine table.
package ofau_pkg;

  // Table and datapath sizes.
  localparam int SINE_DEPTH = 1024;
  localparam int SINE_IDX_W = $clog2(SINE_DEPTH + 1);
  localparam int SINE_W     = 15;
  localparam int ACCEL_W    = 32;
  localparam int FORCE_W    = 24;
  localparam int FACTOR_W   = 24;
  localparam int MASS_W     = 24;
  localparam int TURN_W     = 16;
  localparam int STEP_W     = 16;
  localparam int PROD_W     = FORCE_W + FACTOR_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // The divider takes the product without its low eight bits, over a 24-bit divisor.
  localparam int DIVN_W    = PROD_W - 8;
  localparam int DIVD_W    = MASS_W;
  localparam int DIV_STEPS = DIVN_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int DELTA_W   = DIVN_W + 1;
  localparam int SUM_W     = ((ACCEL_W > DELTA_W) ? ACCEL_W : DELTA_W) + 1;

  // Reset values of the registers that do not reset to zero.
  localparam logic [STEP_W-1:0]   PERIOD_RESET = 16'd10;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 24'd65536;

  // pi/2 in Q2.30.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORCE_X      = 3'd0,
    REG_FORCE_Y      = 3'd1,
    REG_FORCE_Z      = 3'd2,
    REG_PHASE_TURN   = 3'd3,
    REG_PERIOD_STEPS = 3'd4,
    REG_START_STEP   = 3'd5,
    REG_FORCE_FACTOR = 3'd6
  } reg_index_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD_DIV,
    ST_MOD_STORE,
    ST_RATIO_LD,
    ST_RATIO_DIV,
    ST_SINE,
    ST_FMUL,
    ST_FSTORE,
    ST_AMUL,
    ST_ALOAD,
    ST_ADIV,
    ST_AADD,
    ST_AOUT
  } state_t;

  typedef logic [SINE_W-1:0] sine_rom_t [0:SINE_DEPTH];

  // Magnitude of a signed 24-bit value; the most negative value maps to 2^23.
  function automatic logic [FORCE_W-1:0] mag24(logic signed [FORCE_W-1:0] v);
    return v[FORCE_W-1] ? FORCE_W'(-v) : FORCE_W'(v);
  endfunction

  // Quarter-wave sine table in Q1.15, built from an integer Taylor series in Q2.30.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t       rom;
    longint unsigned t;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    int              i;
    int              k;
    for (i = 0; i <= SINE_DEPTH; i++) begin
      t    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_DEPTH);
      term = t;
      sum  = 0;
      for (k = 1; k <= 6; k++) begin
        if ((k & 1) == 1) begin
          sum = sum + longint'(term);
        end else begin
          sum = sum - longint'(term);
        end
        term = (term * t) >> 30;
        term = (term * t) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (64'(sum) + 64'd16384) >> 15;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      rom[i] = v[SINE_W-1:0];
    end
    return rom;
  endfunction

endpackage

/* sv/oscillating_force_accel_update.sv */
`timescale 1ns / 1ps
// Top level of the oscillating force acceleration update, with its sequencer and shared units.
//
// Usage:
// Atom items arrive on the input channel (in_valid / in_stall) carrying mass, the three
// acceleration components and last_atom. Each item gives one result on the output channel
// (out_valid / out_stall): the updated, saturated acceleration, last_out and saturated.
// Registers are written over the configuration channel (cfg_valid / cfg_ready) while idle.
// One shared restoring divider retires one quotient bit a cycle, and one shared 24 x 24
// multiplier serves every product. Each component of an atom takes a product, a division
// and a saturating add; the block takes no new atom until the result of the last one has
// moved to the output register. The atom marked last then recomputes the step force: one
// division for the angle, a table read and three products. A write to a known register also
// recomputes the step force, and start_step first takes its value modulo the period.
// After reset the block computes the first step force before it takes
// a transfer. A finished result waits in the output register while the receiver stalls;
// a new atom is taken meanwhile and its result waits until that register is free.
module oscillating_force_accel_update (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic        [ofau_pkg::MASS_W-1:0]      mass,
  input  logic signed [ofau_pkg::ACCEL_W-1:0]     accel_x,
  input  logic signed [ofau_pkg::ACCEL_W-1:0]     accel_y,
  input  logic signed [ofau_pkg::ACCEL_W-1:0]     accel_z,
  input  logic                                    last_atom,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [ofau_pkg::ACCEL_W-1:0]     new_accel_x,
  output logic signed [ofau_pkg::ACCEL_W-1:0]     new_accel_y,
  output logic signed [ofau_pkg::ACCEL_W-1:0]     new_accel_z,
  output logic                                    last_out,
  output logic                                    saturated,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic        [ofau_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [ofau_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam ofau_pkg::sine_rom_t SINE_ROM = ofau_pkg::build_sine_rom();
  localparam logic [ofau_pkg::DIV_CNT_W-1:0] DIV_LAST =
    ofau_pkg::DIV_CNT_W'(ofau_pkg::DIV_STEPS - 1);
  localparam logic signed [ofau_pkg::ACCEL_W-1:0] ACCEL_MAX =
    {1'b0, {(ofau_pkg::ACCEL_W - 1){1'b1}}};
  localparam logic signed [ofau_pkg::ACCEL_W-1:0] ACCEL_MIN =
    {1'b1, {(ofau_pkg::ACCEL_W - 1){1'b0}}};

  // Configuration registers and step state.
  logic signed [ofau_pkg::FORCE_W-1:0]  force_amp [3];
  logic        [ofau_pkg::TURN_W-1:0]   phase_turn;
  logic        [ofau_pkg::STEP_W-1:0]   period_steps;
  logic        [ofau_pkg::FACTOR_W-1:0] force_factor;
  logic        [ofau_pkg::STEP_W-1:0]   step_counter;
  logic signed [ofau_pkg::FORCE_W-1:0]  step_force [3];
  logic        [ofau_pkg::STEP_W-1:0]   period_eff;

  // Captured atom and the result being built.
  logic        [ofau_pkg::MASS_W-1:0]   mass_q;
  logic signed [ofau_pkg::ACCEL_W-1:0]  accel_q [3];
  logic                                 last_q;
  logic signed [ofau_pkg::ACCEL_W-1:0]  res [3];
  logic                                 sat_q;
  logic        [1:0]                    comp;

  // Sequencer.
  ofau_pkg::state_t state;
  ofau_pkg::state_t state_next;
  logic in_take;
  logic cfg_take;
  logic div_load;
  logic div_step;
  logic mul_en;
  logic fstore;
  logic aadd;
  logic out_load;
  logic cnt_adv;
  logic mod_store;
  logic comp_clr;
  logic [ofau_pkg::DIVN_W-1:0] div_num;
  logic [ofau_pkg::DIVD_W-1:0] div_dsr;

  // Shared divider.
  logic [ofau_pkg::DIVD_W-1:0]    div_rem;
  logic [ofau_pkg::DIVN_W-1:0]    div_quo;
  logic [ofau_pkg::DIVD_W-1:0]    div_den;
  logic [ofau_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [ofau_pkg::DIVD_W:0]      div_trial;
  logic [ofau_pkg::DIVD_W:0]      div_diff;
  logic                           div_ge;

  // Shared multiplier.
  logic [ofau_pkg::FORCE_W-1:0]  mul_a;
  logic [ofau_pkg::FACTOR_W-1:0] mul_b;
  logic [ofau_pkg::PROD_W-1:0]   prod;

  // Angle and sine lookup.
  logic [ofau_pkg::TURN_W-1:0]     angle;
  logic [14:0]                     quad_off;
  logic [ofau_pkg::SINE_IDX_W-1:0] sine_idx;
  logic [ofau_pkg::SINE_W-1:0]     sine_q;
  logic                            sine_neg;

  // Rounding of the step force and the saturating sum.
  logic [ofau_pkg::FORCE_W-1:0]      fmag;
  logic                              fneg;
  logic signed [ofau_pkg::DELTA_W-1:0] delta;
  logic signed [ofau_pkg::SUM_W-1:0]   sum;
  logic [ofau_pkg::SUM_W-ofau_pkg::ACCEL_W:0] sum_top;
  logic                              sum_ovf;
  logic signed [ofau_pkg::ACCEL_W-1:0] sum_clip;
  logic [ofau_pkg::STEP_W:0]         cnt_plus;

  assign period_eff = (period_steps == '0) ? ofau_pkg::STEP_W'(1) : period_steps;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ofau_pkg::ST_RATIO_LD;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control strobes.
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    cfg_ready  = 1'b0;
    in_take    = 1'b0;
    cfg_take   = 1'b0;
    div_load   = 1'b0;
    div_step   = 1'b0;
    mul_en     = 1'b0;
    fstore     = 1'b0;
    aadd       = 1'b0;
    out_load   = 1'b0;
    cnt_adv    = 1'b0;
    mod_store  = 1'b0;
    comp_clr   = 1'b0;
    div_num    = '0;
    div_dsr    = ofau_pkg::DIVD_W'(period_eff);
    case (state)
      ofau_pkg::ST_IDLE: begin
        cfg_ready = 1'b1;
        in_stall  = cfg_valid;
        if (cfg_valid) begin
          cfg_take = 1'b1;
          case (cfg_index)
            ofau_pkg::REG_START_STEP: begin
              div_load   = 1'b1;
              div_num    = ofau_pkg::DIVN_W'(cfg_data[ofau_pkg::STEP_W-1:0]);
              state_next = ofau_pkg::ST_MOD_DIV;
            end
            ofau_pkg::REG_FORCE_X, ofau_pkg::REG_FORCE_Y, ofau_pkg::REG_FORCE_Z,
            ofau_pkg::REG_PHASE_TURN, ofau_pkg::REG_PERIOD_STEPS,
            ofau_pkg::REG_FORCE_FACTOR: begin
              state_next = ofau_pkg::ST_RATIO_LD;
            end
            default: begin
              state_next = ofau_pkg::ST_IDLE;
            end
          endcase
        end else if (in_valid) begin
          in_take    = 1'b1;
          comp_clr   = 1'b1;
          state_next = ofau_pkg::ST_AMUL;
        end
      end
      ofau_pkg::ST_MOD_DIV: begin
        div_step = 1'b1;
        if (div_cnt == DIV_LAST) begin
          state_next = ofau_pkg::ST_MOD_STORE;
        end
      end
      ofau_pkg::ST_MOD_STORE: begin
        mod_store  = 1'b1;
        state_next = ofau_pkg::ST_RATIO_LD;
      end
      ofau_pkg::ST_RATIO_LD: begin
        div_load   = 1'b1;
        div_num    = ofau_pkg::DIVN_W'({step_counter, {ofau_pkg::TURN_W{1'b0}}});
        comp_clr   = 1'b1;
        state_next = ofau_pkg::ST_RATIO_DIV;
      end
      ofau_pkg::ST_RATIO_DIV: begin
        div_step = 1'b1;
        if (div_cnt == DIV_LAST) begin
          state_next = ofau_pkg::ST_SINE;
        end
      end
      ofau_pkg::ST_SINE: begin
        state_next = ofau_pkg::ST_FMUL;
      end
      ofau_pkg::ST_FMUL: begin
        mul_en     = 1'b1;
        state_next = ofau_pkg::ST_FSTORE;
      end
      ofau_pkg::ST_FSTORE: begin
        fstore     = 1'b1;
        state_next = (comp == 2'd2) ? ofau_pkg::ST_IDLE : ofau_pkg::ST_FMUL;
      end
      ofau_pkg::ST_AMUL: begin
        mul_en     = 1'b1;
        state_next = ofau_pkg::ST_ALOAD;
      end
      ofau_pkg::ST_ALOAD: begin
        div_load   = 1'b1;
        div_num    = prod[ofau_pkg::PROD_W-1:8];
        div_dsr    = mass_q;
        state_next = ofau_pkg::ST_ADIV;
      end
      ofau_pkg::ST_ADIV: begin
        div_step = 1'b1;
        if (div_cnt == DIV_LAST) begin
          state_next = ofau_pkg::ST_AADD;
        end
      end
      ofau_pkg::ST_AADD: begin
        aadd       = 1'b1;
        state_next = (comp == 2'd2) ? ofau_pkg::ST_AOUT : ofau_pkg::ST_AMUL;
      end
      ofau_pkg::ST_AOUT: begin
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          if (last_q) begin
            cnt_adv    = 1'b1;
            state_next = ofau_pkg::ST_RATIO_LD;
          end else begin
            state_next = ofau_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ofau_pkg::ST_IDLE;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      force_amp[0] <= '0;
      force_amp[1] <= '0;
      force_amp[2] <= '0;
      phase_turn   <= '0;
      period_steps <= ofau_pkg::PERIOD_RESET;
      force_factor <= ofau_pkg::FACTOR_RESET;
    end else if (cfg_take) begin
      case (cfg_index)
        ofau_pkg::REG_FORCE_X:      force_amp[0] <= cfg_data;
        ofau_pkg::REG_FORCE_Y:      force_amp[1] <= cfg_data;
        ofau_pkg::REG_FORCE_Z:      force_amp[2] <= cfg_data;
        ofau_pkg::REG_PHASE_TURN:   phase_turn   <= cfg_data[ofau_pkg::TURN_W-1:0];
        ofau_pkg::REG_PERIOD_STEPS: period_steps <= cfg_data[ofau_pkg::STEP_W-1:0];
        ofau_pkg::REG_FORCE_FACTOR: force_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  // Step counter: loaded from the start value modulo the period, advanced by the last atom.
  assign cnt_plus = {1'b0, step_counter} + (ofau_pkg::STEP_W + 1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_counter <= '0;
    end else if (mod_store) begin
      step_counter <= div_rem[ofau_pkg::STEP_W-1:0];
    end else if (cnt_adv) begin
      step_counter <= (cnt_plus >= {1'b0, period_eff}) ? '0 : cnt_plus[ofau_pkg::STEP_W-1:0];
    end
  end

  // Shared restoring divider: one quotient bit a cycle, remainder always below the divisor.
  assign div_trial = {div_rem, div_quo[ofau_pkg::DIVN_W-1]};
  assign div_diff  = div_trial - {1'b0, div_den};
  assign div_ge    = (div_trial >= {1'b0, div_den});

  always_ff @(posedge clk) begin
    if (rst) begin
      div_rem <= '0;
      div_quo <= '0;
      div_den <= ofau_pkg::DIVD_W'(1);
      div_cnt <= '0;
    end else if (div_load) begin
      div_rem <= '0;
      div_quo <= div_num;
      div_den <= (div_dsr == '0) ? ofau_pkg::DIVD_W'(1) : div_dsr;
      div_cnt <= '0;
    end else if (div_step) begin
      div_rem <= div_ge ? div_diff[ofau_pkg::DIVD_W-1:0] : div_trial[ofau_pkg::DIVD_W-1:0];
      div_quo <= {div_quo[ofau_pkg::DIVN_W-2:0], div_ge};
      div_cnt <= div_cnt + ofau_pkg::DIV_CNT_W'(1);
    end
  end

  // Shared multiplier, magnitudes only; signs are handled around it.
  always_comb begin
    if (state == ofau_pkg::ST_FMUL) begin
      mul_a = ofau_pkg::mag24(force_amp[comp]);
      mul_b = ofau_pkg::FACTOR_W'(sine_q);
    end else begin
      mul_a = ofau_pkg::mag24(step_force[comp]);
      mul_b = force_factor;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= ofau_pkg::PROD_W'(mul_a) * ofau_pkg::PROD_W'(mul_b);
    end
  end

  // Angle from the ratio quotient plus phase, folded into one quadrant for the table.
  assign angle    = div_quo[ofau_pkg::TURN_W-1:0] + phase_turn;
  assign quad_off = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
  assign sine_idx = ofau_pkg::SINE_IDX_W'((32'(quad_off) * 32'(ofau_pkg::SINE_DEPTH)) >> 14);

  // Registered table read.
  always_ff @(posedge clk) begin
    sine_q   <= SINE_ROM[sine_idx];
    sine_neg <= angle[15];
  end

  // Step force: product rounded half away from zero, sign from force and quadrant.
  assign fmag = ofau_pkg::FORCE_W'((prod[38:0] + 39'd16384) >> 15);
  assign fneg = force_amp[comp][ofau_pkg::FORCE_W-1] ^ sine_neg;

  always_ff @(posedge clk) begin
    if (fstore) begin
      step_force[comp] <= fneg ? ofau_pkg::FORCE_W'(-fmag) : fmag;
    end
  end

  // Component counter shared by both sequences.
  always_ff @(posedge clk) begin
    if (comp_clr) begin
      comp <= '0;
    end else if (fstore || aadd) begin
      comp <= comp + 2'd1;
    end
  end

  // Input capture.
  always_ff @(posedge clk) begin
    if (in_take) begin
      mass_q     <= (mass == '0) ? ofau_pkg::MASS_W'(1) : mass;
      accel_q[0] <= accel_x;
      accel_q[1] <= accel_y;
      accel_q[2] <= accel_z;
      last_q     <= last_atom;
    end
  end

  // Signed delta and saturating sum.
  assign delta = step_force[comp][ofau_pkg::FORCE_W-1] ?
                 -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign sum = $signed({{(ofau_pkg::SUM_W - ofau_pkg::ACCEL_W){accel_q[comp][ofau_pkg::ACCEL_W-1]}},
                        accel_q[comp]})
             + $signed({{(ofau_pkg::SUM_W - ofau_pkg::DELTA_W){delta[ofau_pkg::DELTA_W-1]}},
                        delta});
  assign sum_top  = sum[ofau_pkg::SUM_W-1:ofau_pkg::ACCEL_W-1];
  assign sum_ovf  = !((&sum_top) || !(|sum_top));
  assign sum_clip = sum_ovf ? (sum[ofau_pkg::SUM_W-1] ? ACCEL_MIN : ACCEL_MAX)
                            : sum[ofau_pkg::ACCEL_W-1:0];

  always_ff @(posedge clk) begin
    if (in_take) begin
      sat_q <= 1'b0;
    end else if (aadd) begin
      res[comp] <= sum_clip;
      sat_q     <= sat_q | sum_ovf;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      new_accel_x <= res[0];
      new_accel_y <= res[1];
      new_accel_z <= res[2];
      last_out    <= last_q;
      saturated   <= sat_q;
    end
  end

`ifndef SYNTHESIS
  // An atom transfer and a register write never complete at the same edge.
  assert property (@(posedge clk) disable iff (rst)
    !(in_valid && !in_stall && cfg_valid && cfg_ready))
    else $error("atom transfer and register write at the same edge");

  // The divider remainder stays below its divisor.
  assert property (@(posedge clk) disable iff (rst) div_rem < div_den)
    else $error("divider remainder not below divisor");

  // The last atom either wraps the step counter or advances it by one.
  assert property (@(posedge clk) disable iff (rst)
    (out_load && last_q) |=>
      (step_counter == '0 || step_counter == $past(step_counter) + 16'd1))
    else $error("step counter advance out of order");

  // A result appears only from the output state of the sequencer.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ofau_pkg::ST_AOUT))
    else $error("result shown outside the output state");
`endif

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the oscillating force acceleration update block.

import ofau_pkg::*;

// Sizes of the quarter-wave table and limits of the acceleration sums and the step force.
localparam int     QUARTER_STEPS = 1024;
localparam longint ACCEL_HI      = 64'sd2147483647;
localparam longint ACCEL_LO      = -ACCEL_HI - 1;
localparam longint FORCE_HI      = 64'sd8388607;
localparam longint FORCE_LO      = -FORCE_HI - 1;
localparam int     MAX_PRINTED   = 60;

// One expected result: x, y and z accelerations, the last flag and the clip flag.
typedef struct {
  logic [2:0][ACCEL_W-1:0] accel;
  logic                    last_flag;
  logic                    sat_flag;
} accel_update_t;

// Tracks the registers, the step counter and the per-step force, and keeps the
// accelerations that the block still owes us.
class accel_predictor;
  logic [14:0]        quarter_sine [0:QUARTER_STEPS];
  logic signed [23:0] force_amp [3];
  logic [15:0]        phase_reg;
  logic [15:0]        period_reg;
  logic [15:0]        start_reg;
  logic [23:0]        factor_reg;
  logic [15:0]        step_count;
  longint             step_force [3];
  accel_update_t      pending_accels [$];
  int                 mismatches;

  function new();
    build_quarter_sine();
    force_amp[0] = '0;
    force_amp[1] = '0;
    force_amp[2] = '0;
    phase_reg    = '0;
    period_reg   = 16'd10;
    start_reg    = '0;
    factor_reg   = 24'd65536;
    step_count   = '0;
    mismatches   = 0;
    refresh_step_force();
  endfunction

  // Taylor series of sin(pi/2 * i / depth) in Q2.30, rounded to Q1.15.
  function void build_quarter_sine();
    longint unsigned angle_q30;
    longint unsigned power;
    longint unsigned rounded;
    longint          acc;
    int              i;
    int              k;
    for (i = 0; i <= QUARTER_STEPS; i++) begin
      angle_q30 = (64'd1686629713 * 64'(i)) / 64'(QUARTER_STEPS);
      power     = angle_q30;
      acc       = 0;
      for (k = 1; k <= 6; k++) begin
        if (k % 2 == 1) begin
          acc = acc + longint'(power);
        end else begin
          acc = acc - longint'(power);
        end
        power = (power * angle_q30) >> 30;
        power = (power * angle_q30) >> 30;
        power = power / 64'((2 * k) * (2 * k + 1));
      end
      if (acc < 0) begin
        acc = 0;
      end
      rounded = acc;
      rounded = (rounded + 64'd16384) >> 15;
      if (rounded > 64'd32767) begin
        rounded = 64'd32767;
      end
      quarter_sine[i] = rounded[14:0];
    end
  endfunction

  // Odd quadrants read the table backwards; the upper half-turn is negative.
  function longint sine_at(logic [15:0] angle);
    logic [1:0]  quad;
    int unsigned quad_pos;
    int unsigned idx;
    quad     = angle[15:14];
    quad_pos = quad[0] ? 16384 - angle[13:0] : angle[13:0];
    idx      = (quad_pos * QUARTER_STEPS) >> 14;
    if (idx > QUARTER_STEPS) begin
      idx = QUARTER_STEPS;
    end
    return quad[1] ? -longint'(quarter_sine[idx]) : longint'(quarter_sine[idx]);
  endfunction

  // Force of the current step: amplitude times sine, rounded half away from zero.
  function void refresh_step_force();
    longint unsigned ratio;
    logic [15:0]     angle;
    longint          sine;
    longint          prod;
    longint          mag;
    longint          r;
    int unsigned     per;
    int              a;
    per   = (period_reg == 0) ? 1 : period_reg;
    ratio = (64'(step_count) << 16) / 64'(per);
    angle = 16'(ratio + 64'(phase_reg));
    sine  = sine_at(angle);
    for (a = 0; a < 3; a++) begin
      prod = longint'(force_amp[a]) * sine;
      mag  = (prod < 0) ? -prod : prod;
      r    = (mag + 16384) >> 15;
      if (prod < 0) begin
        r = -r;
      end
      if (r > FORCE_HI) begin
        r = FORCE_HI;
      end
      if (r < FORCE_LO) begin
        r = FORCE_LO;
      end
      step_force[a] = r;
    end
  endfunction

  // Register write; an unknown index changes nothing.
  function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_FORCE_X:      force_amp[0] = data[23:0];
      REG_FORCE_Y:      force_amp[1] = data[23:0];
      REG_FORCE_Z:      force_amp[2] = data[23:0];
      REG_PHASE_TURN:   phase_reg = data[15:0];
      REG_PERIOD_STEPS: period_reg = data[15:0];
      REG_START_STEP: begin
        start_reg  = data[15:0];
        step_count = start_reg % ((period_reg == 0) ? 16'd1 : period_reg);
      end
      REG_FORCE_FACTOR: factor_reg = data[23:0];
      default: return;
    endcase
    refresh_step_force();
  endfunction

  // Accepted atom: work out its updated acceleration and advance the step if last.
  function void note_atom(logic [23:0] m, logic [2:0][ACCEL_W-1:0] acc_in, logic lst);
    longint        divisor;
    longint        prod;
    longint        delta;
    longint        total;
    accel_update_t upd;
    int unsigned   per;
    int            a;
    divisor       = longint'((m == 0) ? 24'd1 : m) << 8;
    upd.sat_flag  = 1'b0;
    upd.last_flag = lst;
    for (a = 0; a < 3; a++) begin
      prod  = step_force[a] * longint'(factor_reg);
      delta = prod / divisor;
      total = longint'($signed(acc_in[a])) + delta;
      if (total > ACCEL_HI) begin
        total        = ACCEL_HI;
        upd.sat_flag = 1'b1;
      end
      if (total < ACCEL_LO) begin
        total        = ACCEL_LO;
        upd.sat_flag = 1'b1;
      end
      upd.accel[a] = total[ACCEL_W-1:0];
    end
    pending_accels.push_back(upd);
    if (lst) begin
      per        = (period_reg == 0) ? 1 : period_reg;
      step_count = (step_count + 32'd1 >= per) ? 16'd0 : step_count + 16'd1;
      refresh_step_force();
    end
  endfunction

  task report_mismatch(string msg);
    if (mismatches < MAX_PRINTED) begin
      $display("%0t ns: mismatch: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // Compare one result with the oldest expectation, field by field.
  task check_accel(logic [2:0][ACCEL_W-1:0] got, logic got_last, logic got_sat);
    accel_update_t want;
    string         axis;
    int            a;
    if (pending_accels.size() == 0) begin
      report_mismatch("result arrived with nothing outstanding");
      return;
    end
    want = pending_accels.pop_front();
    for (a = 0; a < 3; a++) begin
      axis = (a == 0) ? "x" : (a == 1) ? "y" : "z";
      if (got[a] !== want.accel[a]) begin
        report_mismatch($sformatf("new_accel_%s got %0d, wanted %0d", axis,
                                  $signed(got[a]), $signed(want.accel[a])));
      end
    end
    if (got_last !== want.last_flag) begin
      report_mismatch($sformatf("last_out got %b, wanted %b", got_last, want.last_flag));
    end
    if (got_sat !== want.sat_flag) begin
      report_mismatch($sformatf("saturated got %b, wanted %b", got_sat, want.sat_flag));
    end
  endtask
endclass

module tb;
  import ofau_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 3'd7;
  localparam logic [ACCEL_W-1:0]   ACCEL_TOP      = 32'h7FFF_FFFF;
  localparam logic [ACCEL_W-1:0]   ACCEL_BOTTOM   = 32'h8000_0000;
  localparam int                   SETTLE_CYCLES  = 200;
  localparam int                   HOLD_CYCLES    = 1500;
  localparam int                   QUIET_LIMIT    = 20000;
  localparam int                   RANDOM_PHASES  = 12;
  localparam int                   ATOMS_PER_PHASE = 165;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [MASS_W-1:0]       mass;
  logic signed [ACCEL_W-1:0] accel_x;
  logic signed [ACCEL_W-1:0] accel_y;
  logic signed [ACCEL_W-1:0] accel_z;
  logic                    last_atom;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [ACCEL_W-1:0] new_accel_x;
  logic signed [ACCEL_W-1:0] new_accel_y;
  logic signed [ACCEL_W-1:0] new_accel_z;
  logic                    last_out;
  logic                    saturated;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  accel_predictor accel_pred;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  bit             hold_req = 1'b0;
  bit             hold_done = 1'b0;

  oscillating_force_accel_update uut (.*);

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiving side: checks every transfer out and stalls at random, with one long hold-off.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        accel_pred.check_accel({new_accel_z, new_accel_y, new_accel_x}, last_out, saturated);
      end
      if (hold_left == 0 && hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done <= 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run after too long without any transfer.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb failed");
    $finish;
  end

  // One atom transfer, after a random number of idle cycles.
  task automatic send_atom(input logic [MASS_W-1:0] m, input logic [ACCEL_W-1:0] ax,
                           input logic [ACCEL_W-1:0] ay, input logic [ACCEL_W-1:0] az,
                           input logic lst);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    mass      <= m;
    accel_x   <= ax;
    accel_y   <= ay;
    accel_z   <= az;
    last_atom <= lst;
    do @(posedge clk); while (in_stall !== 1'b0);
    accel_pred.note_atom(m, {az, ay, ax}, lst);
  endtask

  // Register write; the caller lowers cfg_valid after its last write.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    accel_pred.apply_reg(idx, val);
  endtask

  // Wait for every outstanding result, then for the step force recompute to finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (accel_pred.pending_accels.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_force();
    case ($urandom_range(0, 5))
      0:       return 24'h7F_FFFF;
      1:       return 24'h80_0000;
      2:       return 24'h00_0000;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // Small periods are favoured so that the counter wraps often.
  function automatic logic [CFG_DATA_W-1:0] pick_period();
    logic [7:0] junk;
    junk = 8'($urandom);
    case ($urandom_range(0, 7))
      0:       return {junk, 16'd0};
      1:       return {junk, 16'd1};
      2:       return {junk, 16'hFFFF};
      3, 4, 5: return {junk, 16'($urandom_range(2, 12))};
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_turn();
    case ($urandom_range(0, 4))
      0:       return 24'h00_0000;
      1:       return 24'hFF_FFFF;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_factor();
    case ($urandom_range(0, 5))
      0:       return 24'h00_0000;
      1:       return 24'hFF_FFFF;
      2:       return 24'h01_0000;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // Light atoms give large changes and clipping; zero mass shows up now and then.
  function automatic logic [MASS_W-1:0] pick_mass();
    case ($urandom_range(0, 15))
      0: begin
        case ($urandom_range(0, 2))
          0:       return 24'd0;
          1:       return 24'd1;
          default: return 24'hFF_FFFF;
        endcase
      end
      1, 2:    return MASS_W'($urandom_range(1, 255));
      3:       return MASS_W'($urandom_range(256, 65535));
      default: return MASS_W'($urandom);
    endcase
  endfunction

  function automatic logic [ACCEL_W-1:0] pick_accel();
    case ($urandom_range(0, 7))
      0:       return ACCEL_TOP - ACCEL_W'($urandom_range(0, 1 << 20));
      1:       return ACCEL_BOTTOM + ACCEL_W'($urandom_range(0, 1 << 20));
      default: return ACCEL_W'($urandom);
    endcase
  endfunction

  // A random new setting; sometimes the period shrinks after the counter is loaded.
  task automatic configure_random();
    if ($urandom_range(0, 2) != 0) cfg_write(REG_FORCE_X, pick_force());
    if ($urandom_range(0, 2) != 0) cfg_write(REG_FORCE_Y, pick_force());
    if ($urandom_range(0, 2) != 0) cfg_write(REG_FORCE_Z, pick_force());
    if ($urandom_range(0, 2) != 0) cfg_write(REG_PHASE_TURN, pick_turn());
    if ($urandom_range(0, 2) != 0) cfg_write(REG_PERIOD_STEPS, pick_period());
    if ($urandom_range(0, 2) != 0) cfg_write(REG_START_STEP, CFG_DATA_W'($urandom));
    if ($urandom_range(0, 2) != 0) cfg_write(REG_FORCE_FACTOR, pick_factor());
    if ($urandom_range(0, 3) == 0) cfg_write(REG_PERIOD_STEPS, pick_period());
    if ($urandom_range(0, 5) == 0) cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Simulation steps of random length, each closed by an atom marked last.
  task automatic run_steps(input int count);
    int left;
    int run;
    int i;
    left = count;
    while (left > 0) begin
      run = $urandom_range(1, 10);
      if (run > left) begin
        run = left;
      end
      for (i = 0; i < run; i++) begin
        send_atom(pick_mass(), pick_accel(), pick_accel(), pick_accel(), i == run - 1);
      end
      left -= run;
    end
  endtask

  // Main sequence.
  initial begin
    int phase;
    accel_pred = new;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    mass      <= '0;
    accel_x   <= '0;
    accel_y   <= '0;
    accel_z   <= '0;
    last_atom <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_FORCE_X;
    cfg_data  <= '0;
    send_idle_pct = 24;
    recv_idle_pct <= 63;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings have zero force, so accelerations pass straight through.
    send_atom(24'd0, ACCEL_TOP, ACCEL_BOTTOM, 32'd0, 1'b0);
    send_atom(24'hFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 1'b1);
    settle();

    // Full-scale forces at a quarter turn, start loaded beyond the period.
    cfg_write(REG_FORCE_X, 24'h7F_FFFF);
    cfg_write(REG_FORCE_Y, 24'h80_0000);
    cfg_write(REG_FORCE_Z, 24'h00_0123);
    cfg_write(REG_FORCE_FACTOR, 24'hFF_FFFF);
    cfg_write(REG_PHASE_TURN, 24'hAB_4000);
    cfg_write(REG_PERIOD_STEPS, 24'h00_0004);
    cfg_write(REG_START_STEP, 24'h00_0006);
    cfg_valid <= 1'b0;
    send_atom(24'd1, ACCEL_TOP, ACCEL_BOTTOM, 32'd0, 1'b0);
    send_atom(24'd1, ACCEL_BOTTOM, ACCEL_TOP, 32'd0, 1'b1);
    send_atom(24'hFF_FFFF, 32'd0, 32'd0, 32'd0, 1'b1);
    send_atom(24'd300, 32'd1000, -32'd1000, 32'd7, 1'b1);
    send_atom(24'd1, ACCEL_TOP, ACCEL_BOTTOM, ACCEL_TOP, 1'b1);
    settle();

    // A zero period behaves as one; an unknown index is ignored.
    cfg_write(REG_PERIOD_STEPS, 24'hFF_0000);
    cfg_write(REG_UNUSED, 24'hFF_FFFF);
    cfg_valid <= 1'b0;
    send_atom(24'd2, 32'd12345, 32'd0, ACCEL_BOTTOM, 1'b1);
    send_atom(24'd0, 32'd0, ACCEL_TOP, 32'd0, 1'b1);
    settle();

    // Longest period, then a shorter one that leaves the counter beyond it.
    cfg_write(REG_PERIOD_STEPS, 24'h00_FFFF);
    cfg_write(REG_START_STEP, 24'h00_C350);
    cfg_write(REG_PHASE_TURN, 24'h00_FFFF);
    cfg_valid <= 1'b0;
    send_atom(24'd7, 32'd0, 32'd0, 32'd0, 1'b1);
    settle();
    cfg_write(REG_PERIOD_STEPS, 24'h00_0003);
    cfg_valid <= 1'b0;
    send_atom(24'd5, 32'd100, 32'd200, 32'd300, 1'b0);
    send_atom(24'd5, 32'd100, 32'd200, 32'd300, 1'b1);
    send_atom(24'd5, 32'd100, 32'd200, 32'd300, 1'b1);
    settle();

    // Zero factor: no change at all.
    cfg_write(REG_FORCE_FACTOR, 24'h00_0000);
    cfg_valid <= 1'b0;
    send_atom(24'd1, ACCEL_TOP, ACCEL_BOTTOM, 32'd1, 1'b1);
    settle();

    // Random part: the idle pattern changes every four settings.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase / 4)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct <= 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct <= 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      configure_random();
      if (phase == 1) begin
        hold_req <= 1'b1;
      end
      run_steps(ATOMS_PER_PHASE);
      settle();
    end

    if (accel_pred.mismatches == 0 && accel_pred.pending_accels.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
